// ===== rtl/core/assert_macros.svh =====
// assertion macros, empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/core/sspe_pkg.sv =====
`timescale 1ns / 1ps
package sspe_pkg;
	localparam int unsigned KEY_REGS = 4;
	localparam logic [1:0] REG_KEY_0 = 2'd0;
	localparam logic [1:0] REG_KEY_1 = 2'd1;
	localparam logic [1:0] REG_KEY_2 = 2'd2;
	localparam logic [1:0] REG_KEY_3 = 2'd3;
	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5c;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [31:0] MAGIC = {8'h54, 8'h35, 8'h4c, 8'h31};
	localparam logic [7:0] VERSION = 8'd2;
	localparam int unsigned FRAME_LEN = 40;

	typedef logic [31:0] word_t;

	function automatic word_t round_k(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [255:0] init_h();
		return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	endfunction

	function automatic word_t rotr(input word_t v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction
endpackage

// ===== rtl/core/sspe_round.sv =====
`timescale 1ns / 1ps
// one sha-256 compression, one round per cycle, rolling 16-word schedule
module sspe_round (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [255:0] h_in,
	input  logic [511:0] blk,
	output logic         done,
	output logic [255:0] h_out
);
	typedef enum logic [1:0] {IDLE, RUN, FIN} st_t;
	st_t                 st_q;
	logic [5:0]          rnd_q;
	sspe_pkg::word_t     w_q [16];
	sspe_pkg::word_t     v_q [8];
	logic [255:0]        hin_q;
	sspe_pkg::word_t     t1, t2, s0, s1, wn;

	always_comb begin
		t1 = v_q[7] + (sspe_pkg::rotr(v_q[4], 6) ^ sspe_pkg::rotr(v_q[4], 11)
			^ sspe_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sspe_pkg::round_k(rnd_q) + w_q[0];
		t2 = (sspe_pkg::rotr(v_q[0], 2) ^ sspe_pkg::rotr(v_q[0], 13)
			^ sspe_pkg::rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		s0 = sspe_pkg::rotr(w_q[1], 7) ^ sspe_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sspe_pkg::rotr(w_q[14], 17) ^ sspe_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= IDLE;
			rnd_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				IDLE: begin
					if (start) begin
						for (int i = 0; i < 16; i++) w_q[i] <= blk[511-32*i -: 32];
						for (int i = 0; i < 8; i++) v_q[i] <= h_in[255-32*i -: 32];
						hin_q <= h_in;
						rnd_q <= '0;
						st_q  <= RUN;
					end
				end
				RUN: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wn;
					v_q[0] <= t1 + t2;
					v_q[1] <= v_q[0];
					v_q[2] <= v_q[1];
					v_q[3] <= v_q[2];
					v_q[4] <= v_q[3] + t1;
					v_q[5] <= v_q[4];
					v_q[6] <= v_q[5];
					v_q[7] <= v_q[6];
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) st_q <= FIN;
				end
				FIN: begin
					for (int i = 0; i < 8; i++)
						h_out[255-32*i -: 32] <= hin_q[255-32*i -: 32] + v_q[i];
					done <= 1'b1;
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/signed_status_packet_encoder.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   status record in tdata
// m_axis    out  m_axis_tvalid/tready   packet word, tuser index, tlast
// cfg       in   cfg_we                 key register index and data
//
// an item takes four sha-256 compressions (start, load, 64 rounds, finish,
// hand-off) on the one round unit, then one output word per cycle while
// m_axis_tready is high
// s_axis_tready is high only while idle; the next item waits for the last word
// output words hold under m_axis_tready low
// arst_n clears the sequencer and the key registers
`include "assert_macros.svh"
module signed_status_packet_encoder #(
	parameter int unsigned PACKET_BYTES = 72
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// sender id, seq_number, main_temp, sump_temp, thermal_code, severity_level,
	// fault_flag, aux_temp_a, aux_temp_b, aux_temp_c, aux_state_codes, zero fill
	input  logic [223:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // packet_word
	output logic [3:0]   m_axis_tuser,  // word_index
	output logic         m_axis_tlast,  // last_word
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	localparam int unsigned NWR = (PACKET_BYTES + 7) / 8;
	localparam int unsigned NWORDS = NWR > 16 ? 16 : NWR;
	localparam logic [3:0] LAST_IDX = 4'(NWORDS - 1);

	typedef enum logic [2:0] {IDLE, IN0, IN1, OUT0, OUT1, SEND, WAITC} st_t;

	st_t          st_q, nxt_q;
	logic [255:0] key_q;
	logic [319:0] frame_q;   // 40 frame bytes, byte 0 on top
	logic [255:0] ih_q;      // inner hash, then tag
	logic [255:0] h_q;
	logic [3:0]   widx_q;
	logic         start_q;
	logic [511:0] blk;
	logic [255:0] h_out;
	logic         done;
	logic [511:0] kx_i, kx_o;
	logic [575:0] pkt;
	logic [1023:0] pkt_ext;
	logic [223:0] d;

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			kx_i[511-8*i -: 8] = key_q[255-8*i -: 8] ^ sspe_pkg::IPAD;
			kx_o[511-8*i -: 8] = key_q[255-8*i -: 8] ^ sspe_pkg::OPAD;
		end
		kx_i[255:0] = {32{sspe_pkg::IPAD}};
		kx_o[255:0] = {32{sspe_pkg::OPAD}};
	end

	// block mux for the shared round unit
	always_comb begin
		case (st_q)
			IN0:  blk = kx_i;
			IN1:  blk = {frame_q, sspe_pkg::PAD_BYTE, 120'd0, 64'd832};
			OUT0: blk = kx_o;
			OUT1: blk = {ih_q, sspe_pkg::PAD_BYTE, 184'd0, 64'd768};
			default: blk = '0;
		endcase
	end

	sspe_round u_round (
		.clk(clk), .arst_n(arst_n), .start(start_q), .h_in(h_q), .blk(blk),
		.done(done), .h_out(h_out)
	);

	assign d = s_axis_tdata;
	assign pkt = {frame_q, ih_q};
	assign pkt_ext = {pkt, 448'd0};
	assign s_axis_tready = (st_q == IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			nxt_q <= IDLE;
			key_q <= '0;
			start_q <= 1'b0;
			widx_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					sspe_pkg::REG_KEY_0: key_q[255:192] <= cfg_data;
					sspe_pkg::REG_KEY_1: key_q[191:128] <= cfg_data;
					sspe_pkg::REG_KEY_2: key_q[127:64] <= cfg_data;
					sspe_pkg::REG_KEY_3: key_q[63:0] <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				IDLE: if (s_axis_tvalid) begin
					frame_q <= {sspe_pkg::MAGIC, sspe_pkg::VERSION, 24'd0,
						d[63:0], d[95:64], d[111:96], d[127:112], d[135:128],
						d[143:136], 7'd0, d[144], 8'd0, d[160:145], d[176:161],
						d[192:177], d[200:193], d[208:201], d[216:209], 24'd0};
					h_q <= sspe_pkg::init_h();
					start_q <= 1'b1;
					st_q <= IN0;
				end
				IN0, IN1, OUT0, OUT1: begin
					st_q <= WAITC;
					nxt_q <= st_q;
				end
				WAITC: if (done) begin
					case (nxt_q)
						IN0: begin h_q <= h_out; start_q <= 1'b1; st_q <= IN1; end
						IN1: begin
							ih_q <= h_out; h_q <= sspe_pkg::init_h();
							start_q <= 1'b1; st_q <= OUT0;
						end
						OUT0: begin h_q <= h_out; start_q <= 1'b1; st_q <= OUT1; end
						OUT1: begin
							ih_q <= h_out; widx_q <= '0;
							m_axis_tvalid <= 1'b1; st_q <= SEND;
						end
						default: st_q <= IDLE;
					endcase
				end
				SEND: if (m_axis_tready) begin
					if (widx_q == LAST_IDX) begin
						m_axis_tvalid <= 1'b0;
						st_q <= IDLE;
					end else begin
						widx_q <= widx_q + 4'd1;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tdata = pkt_ext[1023 - 64*widx_q -: 64];
	assign m_axis_tuser = widx_q;
	assign m_axis_tlast = (widx_q == LAST_IDX);

	`ASSERT_CLK(a_valid_send, clk, arst_n, m_axis_tvalid |-> st_q == SEND, "valid outside send")
	`ASSERT_NEVER(a_rdy_busy, clk, arst_n, s_axis_tready && m_axis_tvalid, "ready while sending")
	`ASSERT_CLK(a_idx_rng, clk, arst_n, m_axis_tvalid |-> widx_q <= LAST_IDX, "index out of range")
	`ASSERT_CLK(a_done_wait, clk, arst_n, done |-> st_q == WAITC, "round done while not waiting")
endmodule
